[rtl/core/gphs_pkg.sv]
package gphs_pkg;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;

    localparam logic [31:0] GOLDEN = 32'h9E37_79B1;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_SET    = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;
    localparam logic [2:0] CMD_MIN    = 3'd5;
    localparam logic [2:0] CMD_MAX    = 3'd6;
    localparam logic [2:0] CMD_AVG    = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_MIX_KEY,
        OP_BUCKET,
        OP_HEAD_LD,
        OP_WALK_RD,
        OP_WALK_CMP,
        OP_ADD_WR,
        OP_ADD_LINK,
        OP_SET_WR,
        OP_RM_UNLINK,
        OP_RM_RDLAST,
        OP_RM_MOVE,
        OP_RM_RELINK,
        OP_RM_HEAD,
        OP_RM_DEC,
        OP_SWEEP,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_RESULT
    } op_t;

    typedef enum logic [2:0] {
        RES_NOT_FOUND,
        RES_FULL,
        RES_PRESENT,
        RES_ENTRY,
        RES_INPUT,
        RES_CLEAR,
        RES_EMPTY,
        RES_STAT
    } res_t;

    typedef struct packed {
        op_t  op;
        res_t res;
    } ctl_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] cmd;
        logic       total_zero;
        logic       full;
        logic       cur_ok;
        logic       hit;
        logic       is_last;
        logic       sweep_last;
        logic       scan_done;
        logic       div_last;
        logic       out_free;
    } stat_t;

    typedef struct packed {
        logic [31:0]        key;
        logic signed [31:0] height;
        logic [31:0]        payload;
    } entry_t;

endpackage

[rtl/core/gphs_ctrl.sv]
module gphs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  gphs_pkg::stat_t stat,
    output gphs_pkg::ctl_t  ctl
);

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_BUCKET,
        S_HEAD_RD,
        S_HEAD_LD,
        S_WALK_RD,
        S_WALK_CMP,
        S_ADD_WR,
        S_ADD_LINK,
        S_SET_WR,
        S_RM_UNLINK,
        S_RM_RDLAST,
        S_RM_MOVE,
        S_RM_RELINK,
        S_RM_BKT,
        S_RM_HEAD,
        S_RM_DEC,
        S_SWEEP,
        S_SCAN_INIT,
        S_SCAN,
        S_DIV_INIT,
        S_DIV,
        S_RESULT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    gphs_pkg::op_t      op_reg;
    gphs_pkg::op_t      op_next;
    gphs_pkg::res_t     res_reg;
    gphs_pkg::res_t     res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (stat.cmd_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd) inside
                    gphs_pkg::CMD_CLEAR:
                    begin
                        state_next = S_SWEEP;
                    end
                    gphs_pkg::CMD_MIN, gphs_pkg::CMD_MAX, gphs_pkg::CMD_AVG:
                    begin
                        if (stat.total_zero)
                        begin
                            state_next = S_RESULT;
                            res_next   = gphs_pkg::RES_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN_INIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_BUCKET;
                    end
                endcase
            end
            S_BUCKET:    state_next = S_HEAD_RD;
            S_HEAD_RD:   state_next = S_HEAD_LD;
            S_HEAD_LD:   state_next = S_WALK_RD;
            S_WALK_RD:
            begin
                if (stat.cur_ok)
                begin
                    state_next = S_WALK_CMP;
                end
                else if (stat.cmd == gphs_pkg::CMD_ADD)
                begin
                    if (stat.full)
                    begin
                        state_next = S_RESULT;
                        res_next   = gphs_pkg::RES_FULL;
                    end
                    else
                    begin
                        state_next = S_ADD_WR;
                    end
                end
                else
                begin
                    state_next = S_RESULT;
                    res_next   = gphs_pkg::RES_NOT_FOUND;
                end
            end
            S_WALK_CMP:
            begin
                if (!stat.hit)
                begin
                    state_next = S_WALK_RD;
                end
                else
                begin
                    unique case (stat.cmd) inside
                        gphs_pkg::CMD_ADD:
                        begin
                            state_next = S_RESULT;
                            res_next   = gphs_pkg::RES_PRESENT;
                        end
                        gphs_pkg::CMD_REMOVE:
                        begin
                            state_next = S_RM_UNLINK;
                        end
                        gphs_pkg::CMD_SET:
                        begin
                            state_next = S_SET_WR;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                            res_next   = gphs_pkg::RES_ENTRY;
                        end
                    endcase
                end
            end
            S_ADD_WR:    state_next = S_ADD_LINK;
            S_ADD_LINK:
            begin
                state_next = S_RESULT;
                res_next   = gphs_pkg::RES_INPUT;
            end
            S_SET_WR:
            begin
                state_next = S_RESULT;
                res_next   = gphs_pkg::RES_INPUT;
            end
            S_RM_UNLINK: state_next = S_RM_RDLAST;
            S_RM_RDLAST: state_next = stat.is_last ? S_RM_DEC : S_RM_MOVE;
            S_RM_MOVE:   state_next = S_RM_RELINK;
            S_RM_RELINK: state_next = S_RM_BKT;
            S_RM_BKT:    state_next = S_RM_HEAD;
            S_RM_HEAD:   state_next = S_RM_DEC;
            S_RM_DEC:
            begin
                state_next = S_RESULT;
                res_next   = gphs_pkg::RES_ENTRY;
            end
            S_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = S_RESULT;
                    res_next   = gphs_pkg::RES_CLEAR;
                end
            end
            S_SCAN_INIT: state_next = S_SCAN;
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.cmd == gphs_pkg::CMD_AVG)
                    begin
                        state_next = S_DIV_INIT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                        res_next   = gphs_pkg::RES_STAT;
                    end
                end
            end
            S_DIV_INIT:  state_next = S_DIV;
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_RESULT;
                    res_next   = gphs_pkg::RES_STAT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (state_next)
            S_INIT:      op_next = gphs_pkg::OP_SWEEP;
            S_IDLE:      op_next = gphs_pkg::OP_ACCEPT;
            S_DISPATCH:  op_next = gphs_pkg::OP_MIX_KEY;
            S_BUCKET:    op_next = gphs_pkg::OP_BUCKET;
            S_HEAD_LD:   op_next = gphs_pkg::OP_HEAD_LD;
            S_WALK_RD:   op_next = gphs_pkg::OP_WALK_RD;
            S_WALK_CMP:  op_next = gphs_pkg::OP_WALK_CMP;
            S_ADD_WR:    op_next = gphs_pkg::OP_ADD_WR;
            S_ADD_LINK:  op_next = gphs_pkg::OP_ADD_LINK;
            S_SET_WR:    op_next = gphs_pkg::OP_SET_WR;
            S_RM_UNLINK: op_next = gphs_pkg::OP_RM_UNLINK;
            S_RM_RDLAST: op_next = gphs_pkg::OP_RM_RDLAST;
            S_RM_MOVE:   op_next = gphs_pkg::OP_RM_MOVE;
            S_RM_RELINK: op_next = gphs_pkg::OP_RM_RELINK;
            S_RM_BKT:    op_next = gphs_pkg::OP_BUCKET;
            S_RM_HEAD:   op_next = gphs_pkg::OP_RM_HEAD;
            S_RM_DEC:    op_next = gphs_pkg::OP_RM_DEC;
            S_SWEEP:     op_next = gphs_pkg::OP_SWEEP;
            S_SCAN_INIT: op_next = gphs_pkg::OP_SCAN_INIT;
            S_SCAN:      op_next = gphs_pkg::OP_SCAN;
            S_DIV_INIT:  op_next = gphs_pkg::OP_DIV_INIT;
            S_DIV:       op_next = gphs_pkg::OP_DIV_STEP;
            S_RESULT:    op_next = gphs_pkg::OP_RESULT;
            default:     op_next = gphs_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            op_reg    <= gphs_pkg::OP_SWEEP;
            res_reg   <= gphs_pkg::RES_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            res_reg   <= res_next;
        end
    end

    assign ctl.op  = op_reg;
    assign ctl.res = res_reg;

endmodule

[rtl/core/gphs_dp.sv]
module gphs_dp #(
    parameter int BUCKETS  = 1024,
    parameter int CAPACITY = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gphs_pkg::ctl_t                 ctl,
    output gphs_pkg::stat_t                stat,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [2:0]                     command,
    input  logic signed [15:0]             pos_x,
    input  logic signed [15:0]             pos_y,
    input  logic signed [31:0]             height_in,
    input  logic [31:0]                    payload_in,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [2:0]                     status,
    output logic [gphs_pkg::IDX_W-1:0]     entry_index,
    output logic signed [31:0]             height_out,
    output logic [31:0]                    payload_out,
    output logic [gphs_pkg::CNT_W-1:0]     count
);

    localparam int IW    = $clog2(CAPACITY);
    localparam int LW    = IW + 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int BW    = $clog2(BUCKETS);
    localparam int PW    = 33 + BW;
    localparam int SUM_W = 33 + CW;
    localparam int DCW   = $clog2(SUM_W);
    localparam logic [LW-1:0] NONE = {1'b1, {IW{1'b0}}};

    gphs_pkg::entry_t data_mem [CAPACITY];
    logic [LW-1:0]    next_mem [CAPACITY];
    logic [LW-1:0]    prev_mem [CAPACITY];
    logic [LW-1:0]    head_mem [BUCKETS];

    gphs_pkg::entry_t data_q;
    logic [LW-1:0]    next_q;
    logic [LW-1:0]    prev_q;
    logic [LW-1:0]    head_q;

    logic [2:0]               cmd_reg;
    logic [31:0]              key_reg;
    logic signed [31:0]       hin_reg;
    logic [31:0]              pin_reg;
    logic [31:0]              mix_reg;
    logic [BW-1:0]            bkt_reg;
    logic [LW-1:0]            head_reg;
    logic [LW-1:0]            cur_reg;
    logic [CW-1:0]            guard_reg;
    gphs_pkg::entry_t         vdata_reg;
    logic [LW-1:0]            vnext_reg;
    logic [LW-1:0]            vprev_reg;
    logic [31:0]              lkey_reg;
    logic [LW-1:0]            lp_reg;
    logic [LW-1:0]            ln_reg;
    logic [CW-1:0]            total_reg;
    logic [BW-1:0]            sweep_reg;
    logic [CW-1:0]            scan_reg;
    logic                     pend_reg;
    logic                     first_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [31:0]       best_reg;
    logic [SUM_W-1:0]         dvd_reg;
    logic [CW-1:0]            rem_reg;
    logic [SUM_W-1:0]         quo_reg;
    logic [DCW-1:0]           div_reg;
    logic                     neg_reg;
    logic                     rsp_valid_reg;
    logic [2:0]               status_reg;
    logic [gphs_pkg::IDX_W-1:0] index_reg;
    logic signed [31:0]       height_reg;
    logic [31:0]              payload_reg;
    logic [gphs_pkg::CNT_W-1:0] count_reg;

    logic [IW-1:0]     cur_idx;
    logic [IW-1:0]     tot_idx;
    logic [IW-1:0]     last_idx;
    logic [IW-1:0]     ra;
    logic              d_we;
    logic [IW-1:0]     d_wa;
    gphs_pkg::entry_t  d_wd;
    logic              n_we;
    logic [IW-1:0]     n_wa;
    logic [LW-1:0]     n_wd;
    logic              p_we;
    logic [IW-1:0]     p_wa;
    logic [LW-1:0]     p_wd;
    logic              h_we;
    logic [BW-1:0]     h_wa;
    logic [LW-1:0]     h_wd;
    logic [PW-1:0]     prod;
    logic              hit;
    logic              out_free;
    logic              scan_more;
    logic [SUM_W-1:0]  mag;
    logic [CW:0]       trial;
    logic              ge;
    logic signed [31:0] stat_h;
    logic [31:0]       quo_low;
    logic              accept;

    assign cur_idx  = cur_reg[IW-1:0];
    assign tot_idx  = total_reg[IW-1:0];
    assign last_idx = IW'(total_reg - CW'(1));
    assign prod     = PW'(mix_reg) * PW'(BUCKETS);
    assign hit      = data_q.key == key_reg;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign scan_more = scan_reg < total_reg;
    assign mag      = sum_reg[SUM_W-1] ? (SUM_W'(0) - $unsigned(sum_reg)) : $unsigned(sum_reg);
    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign ge       = trial >= {1'b0, total_reg};
    assign quo_low  = quo_reg[31:0];
    assign stat_h   = (cmd_reg == gphs_pkg::CMD_AVG)
                    ? $signed(neg_reg ? (32'd0 - quo_low) : quo_low) : best_reg;
    assign accept   = (ctl.op == gphs_pkg::OP_ACCEPT) && cmd_valid;
    assign cmd_stall = ctl.op != gphs_pkg::OP_ACCEPT;

    always_comb
    begin
        ra   = cur_idx;
        d_we = 1'b0;
        d_wa = cur_idx;
        d_wd = '{key: key_reg, height: hin_reg, payload: pin_reg};
        n_we = 1'b0;
        n_wa = cur_idx;
        n_wd = cur_reg;
        p_we = 1'b0;
        p_wa = cur_idx;
        p_wd = cur_reg;
        h_we = 1'b0;
        h_wa = bkt_reg;
        h_wd = cur_reg;
        unique case (ctl.op)
            gphs_pkg::OP_RM_RDLAST:
            begin
                ra = last_idx;
            end
            gphs_pkg::OP_SCAN:
            begin
                ra = scan_reg[IW-1:0];
            end
            gphs_pkg::OP_ADD_WR:
            begin
                d_we = 1'b1;
                d_wa = tot_idx;
                n_we = 1'b1;
                n_wa = tot_idx;
                n_wd = head_reg;
                p_we = 1'b1;
                p_wa = tot_idx;
                p_wd = NONE;
                h_we = 1'b1;
                h_wd = {1'b0, tot_idx};
            end
            gphs_pkg::OP_ADD_LINK:
            begin
                p_we = !head_reg[IW];
                p_wa = head_reg[IW-1:0];
            end
            gphs_pkg::OP_SET_WR:
            begin
                d_we = 1'b1;
            end
            gphs_pkg::OP_RM_UNLINK:
            begin
                n_we = !vprev_reg[IW];
                n_wa = vprev_reg[IW-1:0];
                n_wd = vnext_reg;
                p_we = !vnext_reg[IW];
                p_wa = vnext_reg[IW-1:0];
                p_wd = vprev_reg;
                h_we = vprev_reg[IW];
                h_wd = vnext_reg;
            end
            gphs_pkg::OP_RM_MOVE:
            begin
                d_we = 1'b1;
                d_wd = data_q;
                n_we = 1'b1;
                n_wd = next_q;
                p_we = 1'b1;
                p_wd = prev_q;
            end
            gphs_pkg::OP_RM_RELINK:
            begin
                n_we = !lp_reg[IW];
                n_wa = lp_reg[IW-1:0];
                p_we = !ln_reg[IW];
                p_wa = ln_reg[IW-1:0];
            end
            gphs_pkg::OP_RM_HEAD:
            begin
                h_we = lp_reg[IW];
            end
            gphs_pkg::OP_SWEEP:
            begin
                h_we = 1'b1;
                h_wa = sweep_reg;
                h_wd = NONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            data_mem[d_wa] <= d_wd;
        end
        data_q <= data_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            next_mem[n_wa] <= n_wd;
        end
        next_q <= next_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prev_mem[p_wa] <= p_wd;
        end
        prev_q <= prev_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            head_mem[h_wa] <= h_wd;
        end
        head_q <= head_mem[bkt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            key_reg <= {pos_x, pos_y};
            hin_reg <= height_in;
            pin_reg <= payload_in;
        end
        unique case (ctl.op)
            gphs_pkg::OP_MIX_KEY:
            begin
                mix_reg <= key_reg * gphs_pkg::GOLDEN;
            end
            gphs_pkg::OP_BUCKET:
            begin
                bkt_reg <= prod[32+BW-1:32];
            end
            gphs_pkg::OP_HEAD_LD:
            begin
                cur_reg   <= head_q;
                head_reg  <= head_q;
                guard_reg <= '0;
            end
            gphs_pkg::OP_WALK_CMP:
            begin
                vdata_reg <= data_q;
                vnext_reg <= next_q;
                vprev_reg <= prev_q;
                if (!hit)
                begin
                    cur_reg   <= next_q;
                    guard_reg <= guard_reg + CW'(1);
                end
            end
            gphs_pkg::OP_ADD_WR:
            begin
                cur_reg <= {1'b0, tot_idx};
            end
            gphs_pkg::OP_RM_MOVE:
            begin
                lkey_reg <= data_q.key;
                lp_reg   <= prev_q;
                ln_reg   <= next_q;
            end
            gphs_pkg::OP_RM_RELINK:
            begin
                mix_reg <= lkey_reg * gphs_pkg::GOLDEN;
            end
            gphs_pkg::OP_SCAN_INIT:
            begin
                scan_reg  <= '0;
                pend_reg  <= 1'b0;
                first_reg <= 1'b1;
                sum_reg   <= '0;
            end
            gphs_pkg::OP_SCAN:
            begin
                pend_reg <= scan_more;
                if (scan_more)
                begin
                    scan_reg <= scan_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    first_reg <= 1'b0;
                    sum_reg   <= sum_reg + SUM_W'(data_q.height);
                    if (first_reg
                        || ((cmd_reg == gphs_pkg::CMD_MIN) && (data_q.height < best_reg))
                        || ((cmd_reg != gphs_pkg::CMD_MIN) && (data_q.height > best_reg)))
                    begin
                        best_reg <= data_q.height;
                    end
                end
            end
            gphs_pkg::OP_DIV_INIT:
            begin
                dvd_reg <= mag + SUM_W'(total_reg >> 1);
                rem_reg <= '0;
                quo_reg <= '0;
                div_reg <= '0;
                neg_reg <= sum_reg[SUM_W-1];
            end
            gphs_pkg::OP_DIV_STEP:
            begin
                rem_reg <= ge ? CW'(trial - {1'b0, total_reg}) : trial[CW-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], ge};
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
                div_reg <= div_reg + DCW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (ctl.op)
                gphs_pkg::OP_SWEEP:
                begin
                    total_reg <= '0;
                    sweep_reg <= stat.sweep_last ? '0 : sweep_reg + BW'(1);
                end
                gphs_pkg::OP_ADD_LINK:
                begin
                    total_reg <= total_reg + CW'(1);
                end
                gphs_pkg::OP_RM_DEC:
                begin
                    total_reg <= total_reg - CW'(1);
                end
                default:
                begin
                end
            endcase
            if ((ctl.op == gphs_pkg::OP_RESULT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((ctl.op == gphs_pkg::OP_RESULT) && out_free)
        begin
            count_reg   <= gphs_pkg::CNT_W'(total_reg);
            status_reg  <= gphs_pkg::ST_OK;
            index_reg   <= '0;
            height_reg  <= '0;
            payload_reg <= '0;
            case (ctl.res)
                gphs_pkg::RES_NOT_FOUND:
                begin
                    status_reg <= gphs_pkg::ST_NOT_FOUND;
                end
                gphs_pkg::RES_FULL:
                begin
                    status_reg <= gphs_pkg::ST_FULL;
                end
                gphs_pkg::RES_PRESENT:
                begin
                    status_reg  <= gphs_pkg::ST_PRESENT;
                    index_reg   <= gphs_pkg::IDX_W'(cur_idx);
                    height_reg  <= vdata_reg.height;
                    payload_reg <= vdata_reg.payload;
                end
                gphs_pkg::RES_ENTRY:
                begin
                    index_reg   <= gphs_pkg::IDX_W'(cur_idx);
                    height_reg  <= vdata_reg.height;
                    payload_reg <= vdata_reg.payload;
                end
                gphs_pkg::RES_INPUT:
                begin
                    index_reg   <= gphs_pkg::IDX_W'(cur_idx);
                    height_reg  <= hin_reg;
                    payload_reg <= pin_reg;
                end
                gphs_pkg::RES_EMPTY:
                begin
                    status_reg <= gphs_pkg::ST_EMPTY;
                end
                gphs_pkg::RES_STAT:
                begin
                    height_reg <= stat_h;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.cmd_valid  = cmd_valid;
    assign stat.cmd        = cmd_reg;
    assign stat.total_zero = total_reg == '0;
    assign stat.full       = total_reg >= CW'(CAPACITY);
    assign stat.cur_ok     = !cur_reg[IW] && (CW'(cur_idx) < total_reg)
                           && (guard_reg < CW'(CAPACITY));
    assign stat.hit        = hit;
    assign stat.is_last    = cur_idx == last_idx;
    assign stat.sweep_last = sweep_reg == BW'(BUCKETS - 1);
    assign stat.scan_done  = !scan_more && !pend_reg;
    assign stat.div_last   = div_reg == DCW'(SUM_W - 1);
    assign stat.out_free   = out_free;

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign entry_index = index_reg;
    assign height_out  = height_reg;
    assign payload_out = payload_reg;
    assign count       = count_reg;

endmodule

[rtl/core/grid_point_hash_set.sv]
// One command beat in, one result beat out; the next command is taken the cycle after the
// result is registered. A lookup hashes the key, reads its bucket head and walks the chain;
// a new point is written and linked at the head, set rewrites the entry and remove unlinks
// it and moves the last entry into its slot. Min, max and average scan every entry, average
// then divides the sum by the count; clear sweeps every bucket; a stalled result beat holds
// off the next command. After rst_n a sweep empties every bucket before the first beat is taken.
module grid_point_hash_set #(
    parameter int BUCKETS  = 1024,
    parameter int CAPACITY = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic [2:0]                 command,
    input  logic signed [15:0]         pos_x,
    input  logic signed [15:0]         pos_y,
    input  logic signed [31:0]         height_in,
    input  logic [31:0]                payload_in,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [2:0]                 status,
    output logic [gphs_pkg::IDX_W-1:0] entry_index,
    output logic signed [31:0]         height_out,
    output logic [31:0]                payload_out,
    output logic [gphs_pkg::CNT_W-1:0] count
);

    gphs_pkg::ctl_t  ctl;
    gphs_pkg::stat_t stat;

    gphs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    gphs_dp #(
        .BUCKETS  (BUCKETS),
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .height_in   (height_in),
        .payload_in  (payload_in),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .entry_index (entry_index),
        .height_out  (height_out),
        .payload_out (payload_out),
        .count       (count)
    );

endmodule
